// File: rtl/wts_pkg.sv
//------------------------------------------------------------------------------
// wts_pkg
// Shared types, constants and byte classification for the word tokenizer.
//------------------------------------------------------------------------------
`default_nettype none

package wts_pkg;

	localparam int PENDING_DEPTH_DEF = 16;

	localparam logic [7:0] HYPHEN_BYTE     = 8'd45;
	localparam logic [7:0] APOSTROPHE_BYTE = 8'd39;

	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_MARK = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic fetch;
		logic step_pend;
		logic step_final;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_alpha;
		logic pend_empty;
		logic fl_last;
		logic slot_free;
	} sts_t;

	// Outcome of running one confirmed byte through the word rules.
	typedef struct packed {
		logic       emit;
		logic       kind;
		logic [7:0] code;
		logic       word_open;
	} wb_t;

	function automatic logic is_alpha(input logic [7:0] b);
		return (b >= 8'd65 && b <= 8'd90) || (b >= 8'd97 && b <= 8'd122);
	endfunction

	function automatic logic is_space(input logic [7:0] b);
		return (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
	endfunction

	function automatic logic is_punct(input logic [7:0] b);
		return (b >= 8'd33 && b <= 8'd47) || (b >= 8'd58 && b <= 8'd64) ||
			(b >= 8'd91 && b <= 8'd96) || (b >= 8'd123 && b <= 8'd126);
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] b);
		return (b >= 8'd65 && b <= 8'd90) ? b + 8'd32 : b;
	endfunction

	function automatic wb_t word_step(input logic [7:0] b, input logic word_open,
		input logic [7:0] prev);
		wb_t r;
		r.emit      = 1'b0;
		r.kind      = KIND_CHAR;
		r.code      = 8'd0;
		r.word_open = word_open;
		if (!is_punct(b)) begin
			r.emit      = 1'b1;
			r.code      = to_lower(b);
			r.word_open = 1'b1;
		end else if (b == HYPHEN_BYTE && word_open) begin
			r.emit      = 1'b1;
			r.kind      = KIND_MARK;
			r.word_open = 1'b0;
		end else if (b == APOSTROPHE_BYTE) begin
			r.emit      = 1'b1;
			r.code      = b;
			r.word_open = 1'b1;
		end else if (is_alpha(prev) && word_open) begin
			r.emit      = 1'b1;
			r.kind      = KIND_MARK;
			r.word_open = 1'b0;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: rtl/wts_ctrl.sv
//------------------------------------------------------------------------------
// wts_ctrl
// Sequencer: takes items and walks the pending buffer when a letter arrives.
//------------------------------------------------------------------------------
`default_nettype none

module wts_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire wts_pkg::sts_t sts,
	output wts_pkg::cmd_t      cmd
);
	import wts_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_FETCH = 4'b0010,
		ST_EMIT  = 4'b0100,
		ST_FINAL = 4'b1000
	} state_t;

	state_t state_q, state_d;

	assign in_stall = !(state_q == ST_IDLE && sts.slot_free);

	always_comb begin
		cmd.accept     = in_valid && !in_stall;
		cmd.fetch      = (state_q == ST_FETCH);
		cmd.step_pend  = (state_q == ST_EMIT) && sts.slot_free;
		cmd.step_final = (state_q == ST_FINAL) && sts.slot_free;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.accept && sts.in_alpha && !sts.pend_empty) state_d = ST_FETCH;
			end
			ST_FETCH: state_d = ST_EMIT;
			ST_EMIT: begin
				if (cmd.step_pend) state_d = sts.fl_last ? ST_FINAL : ST_FETCH;
			end
			ST_FINAL: begin
				if (cmd.step_final) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

endmodule

`default_nettype wire

// File: rtl/wts_dp.sv
//------------------------------------------------------------------------------
// wts_dp
// Token state, pending byte memory, word rules and the output register.
//------------------------------------------------------------------------------
`default_nettype none

module wts_dp #(
	parameter int PENDING_DEPTH = wts_pkg::PENDING_DEPTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [7:0]    ch,
	input  wire logic          end_of_input,
	input  wire wts_pkg::cmd_t cmd,
	output wts_pkg::sts_t      sts,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic               kind,
	output logic [7:0]         out_char,
	output logic               last,
	output logic               overflow
);
	import wts_pkg::*;

	localparam int CNT_W = $clog2(PENDING_DEPTH + 1);
	localparam int IDX_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

	logic [7:0]       mem_q [PENDING_DEPTH];
	logic [7:0]       rd_data_q;
	logic [7:0]       hold_q;
	logic [7:0]       prev_q;
	logic             seen_q, open_q, dropped_q;
	logic [CNT_W-1:0] count_q, fl_idx_q;

	logic             out_valid_q, kind_q, last_q, ovf_q;
	logic [7:0]       char_q;

	logic             in_sep, in_alpha, slot_free, push_ok;
	wb_t              wb_in, wb_pend, wb_fin;
	logic             ld, ld_kind, ld_last;
	logic [7:0]       ld_char;

	assign in_sep    = end_of_input || is_space(ch);
	assign in_alpha  = !end_of_input && is_alpha(ch);
	assign slot_free = !out_valid_q || !out_stall;
	assign push_ok   = count_q < CNT_W'(PENDING_DEPTH);

	assign wb_in   = word_step(ch, open_q, prev_q);
	assign wb_pend = word_step(rd_data_q, open_q, prev_q);
	assign wb_fin  = word_step(hold_q, open_q, prev_q);

	always_comb begin
		sts.in_alpha   = in_alpha;
		sts.pend_empty = (count_q == '0);
		sts.fl_last    = ((fl_idx_q + CNT_W'(1)) == count_q);
		sts.slot_free  = slot_free;
	end

	// Result selection for the output register.
	always_comb begin
		ld      = 1'b0;
		ld_kind = KIND_CHAR;
		ld_char = 8'd0;
		ld_last = 1'b0;
		if (cmd.accept) begin
			if (in_sep) begin
				ld      = open_q;
				ld_kind = KIND_MARK;
				ld_last = 1'b1;
			end else if (in_alpha && count_q == '0) begin
				ld      = 1'b1;
				ld_kind = wb_in.kind;
				ld_char = wb_in.code;
				ld_last = 1'b1;
			end
		end else if (cmd.step_pend) begin
			ld      = wb_pend.emit;
			ld_kind = wb_pend.kind;
			ld_char = wb_pend.code;
		end else if (cmd.step_final) begin
			ld      = 1'b1;
			ld_kind = wb_fin.kind;
			ld_char = wb_fin.code;
			ld_last = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && !in_sep && !in_alpha && seen_q && push_ok)
			mem_q[count_q[IDX_W-1:0]] <= ch;
		if (cmd.fetch) rd_data_q <= mem_q[fl_idx_q[IDX_W-1:0]];
		if (cmd.accept) hold_q <= ch;
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			kind_q <= ld_kind;
			char_q <= ld_char;
			last_q <= ld_last;
			ovf_q  <= dropped_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q    <= 1'b0;
			open_q    <= 1'b0;
			dropped_q <= 1'b0;
			prev_q    <= 8'd0;
			count_q   <= '0;
			fl_idx_q  <= '0;
		end else if (cmd.accept) begin
			if (in_sep) begin
				seen_q    <= 1'b0;
				open_q    <= 1'b0;
				dropped_q <= 1'b0;
				prev_q    <= 8'd0;
				count_q   <= '0;
			end else if (in_alpha) begin
				seen_q   <= 1'b1;
				fl_idx_q <= '0;
				// With nothing pending the letter is finished right here.
				if (count_q == '0) begin
					open_q <= wb_in.word_open;
					prev_q <= ch;
				end
			end else if (seen_q) begin
				if (push_ok) count_q <= count_q + CNT_W'(1);
				else dropped_q <= 1'b1;
			end
		end else if (cmd.step_pend) begin
			open_q   <= wb_pend.word_open;
			prev_q   <= rd_data_q;
			fl_idx_q <= fl_idx_q + CNT_W'(1);
			if (sts.fl_last) count_q <= '0;
		end else if (cmd.step_final) begin
			open_q <= wb_fin.word_open;
			prev_q <= hold_q;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign out_char  = char_q;
	assign last      = last_q;
	assign overflow  = ovf_q;

	a_load_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		ld |-> slot_free)
		else $error("output register loaded while a stalled result waits");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(PENDING_DEPTH))
		else $error("pending count beyond buffer depth");

	a_mark_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && kind_q == KIND_MARK) |-> (char_q == 8'd0))
		else $error("end-of-word mark carries a character");

	a_final_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step_final |=> (out_valid_q && last_q && kind_q == KIND_CHAR))
		else $error("closing letter of a flush not flagged as last");

endmodule

`default_nettype wire

// File: rtl/word_tokenizer_stream.sv
//------------------------------------------------------------------------------
// word_tokenizer_stream
// Byte stream to lower-cased word characters and end-of-word marks.
//------------------------------------------------------------------------------
// A byte that closes a token, a letter with nothing pending, or a non-letter
// that is buffered or dropped is finished when it is accepted. A letter that
// confirms pending bytes walks them in order: the pending buffer is a memory
// with a registered read port, so each pending byte is read, then run through
// the word rules and loaded into the output register, and the letter follows.
// One result leaves per cycle at most, and a stalled output holds the input.
//------------------------------------------------------------------------------
`default_nettype none

module word_tokenizer_stream #(
	parameter int PENDING_DEPTH = wts_pkg::PENDING_DEPTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] ch,
	input  wire logic       end_of_input,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            kind,
	output logic [7:0]      out_char,
	output logic            last,
	output logic            overflow
);
	import wts_pkg::*;

	cmd_t cmd;
	sts_t sts;

	wts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	wts_dp #(
		.PENDING_DEPTH (PENDING_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ch           (ch),
		.end_of_input (end_of_input),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.out_char     (out_char),
		.last         (last),
		.overflow     (overflow)
	);

endmodule

`default_nettype wire

// File: test/tb_top.sv
//------------------------------------------------------------------------------
// tb_top
// Self-checking bench for word_tokenizer_stream. A short table of directed
// items opens the run, then random tokens with random letters, filler runs
// and closers follow, mixed with raw noise bytes. Every accepted item goes
// through a local tokenizer model, and each result leaving the block is
// compared with the oldest predicted one. Both sides idle at random.
//------------------------------------------------------------------------------
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import wts_pkg::*;

	localparam int PEND      = PENDING_DEPTH_DEF;
	localparam int N_RANDOM  = 320;
	localparam int HOLD_CYC  = 400;
	localparam int CALM_TAIL = 60;

	typedef struct packed {
		logic       kind;
		logic [7:0] code;
		logic       last;
		logic       ovf;
	} word_res_t;

	typedef struct {
		logic [7:0] b;
		logic       eoi;
		int         reps;
		bit         typed;
		logic       tk;
		logic [7:0] tc;
		logic       tov;
	} dir_row_t;

	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       in_valid     = 1'b0;
	logic [7:0] ch           = 8'h00;
	logic       end_of_input = 1'b0;
	logic       out_stall    = 1'b0;
	logic       in_stall;
	logic       out_valid;
	logic       kind;
	logic [7:0] out_char;
	logic       last;
	logic       overflow;

	// Tokenizer model state.
	bit         tk_seen;
	bit         tk_open;
	logic [7:0] tk_prev;
	logic [7:0] pend_buf [0:PEND-1];
	int         pend_n;
	bit         tk_dropped;
	word_res_t  step_res [0:PEND];
	int         step_n;

	word_res_t  want_q [$];
	word_res_t  got_exp;
	dir_row_t   dir_rows [$];

	int n_err;
	int n_sent;
	int n_closes;
	int n_words;
	int n_ovf_res;
	int max_burst;
	bit calm;
	bit hold_req;
	bit drain_req;

	word_tokenizer_stream u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.ch           (ch),
		.end_of_input (end_of_input),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.out_char     (out_char),
		.last         (last),
		.overflow     (overflow)
	);

	always #6 clk = ~clk;

	function bit letter_b(input logic [7:0] b);
		logic [7:0] f;
		f = b | 8'h20;
		return f >= "a" && f <= "z";
	endfunction

	function bit blank_b(input logic [7:0] b);
		return b == " " || (b >= 8'd9 && b <= 8'd13);
	endfunction

	// Printable, and neither a letter nor a digit.
	function bit punct_b(input logic [7:0] b);
		return b >= 8'd33 && b <= 8'd126 && !letter_b(b) && !(b >= "0" && b <= "9");
	endfunction

	function logic [7:0] fold_case(input logic [7:0] b);
		return (b >= "A" && b <= "Z") ? (b | 8'h20) : b;
	endfunction

	function void stage(input logic k, input logic [7:0] c);
		step_res[step_n] = '{kind: k, code: c, last: 1'b0, ovf: tk_dropped};
		step_n++;
	endfunction

	// Adds one predicted result behind the ones already waiting.
	function void append_want(input word_res_t r);
		want_q.insert(want_q.size(), r);
	endfunction

	// Word rules for one byte that a letter has confirmed.
	function void confirm_byte(input logic [7:0] b);
		if (!punct_b(b)) begin
			stage(KIND_CHAR, fold_case(b));
			tk_open = 1'b1;
		end else if (b == HYPHEN_BYTE && tk_open) begin
			stage(KIND_MARK, 8'h00);
			tk_open = 1'b0;
		end else if (b == APOSTROPHE_BYTE) begin
			stage(KIND_CHAR, b);
			tk_open = 1'b1;
		end else if (letter_b(tk_prev) && tk_open) begin
			stage(KIND_MARK, 8'h00);
			tk_open = 1'b0;
		end
		tk_prev = b;
	endfunction

	function void tokenize_byte(input logic [7:0] b, input logic eoi);
		step_n = 0;
		if (eoi || blank_b(b)) begin
			if (tk_open)
				stage(KIND_MARK, 8'h00);
			tk_seen    = 1'b0;
			tk_open    = 1'b0;
			tk_prev    = 8'h00;
			pend_n     = 0;
			tk_dropped = 1'b0;
		end else if (letter_b(b)) begin
			tk_seen = 1'b1;
			for (int i = 0; i < pend_n; i++)
				confirm_byte(pend_buf[i]);
			pend_n = 0;
			confirm_byte(b);
		end else if (tk_seen) begin
			if (pend_n < PEND) begin
				pend_buf[pend_n] = b;
				pend_n++;
			end else begin
				tk_dropped = 1'b1;
			end
		end
		if (step_n > 0)
			step_res[step_n-1].last = 1'b1;
	endfunction

	function logic [7:0] rand_letter();
		return ($urandom_range(0, 1) ? 8'd65 : 8'd97) + 8'($urandom_range(0, 25));
	endfunction

	function logic [7:0] rand_filler();
		logic [7:0] b;
		case ($urandom_range(0, 7))
			0: b = HYPHEN_BYTE;
			1: b = APOSTROPHE_BYTE;
			2, 3: begin
				do b = 8'($urandom_range(33, 126)); while (!punct_b(b));
			end
			4: b = 8'($urandom_range(48, 57));
			5: b = 8'($urandom_range(128, 255));
			6: begin
				do b = 8'($urandom_range(0, 31)); while (blank_b(b));
				if ($urandom_range(0, 7) == 0)
					b = 8'd127;
			end
			default: begin
				do b = 8'($urandom_range(0, 255)); while (letter_b(b) || blank_b(b));
			end
		endcase
		return b;
	endfunction

	function logic [7:0] rand_blank();
		return ($urandom_range(0, 2) == 0) ? 8'($urandom_range(9, 13)) : 8'd32;
	endfunction

	// Offers one item, waits for the handshake and records what it should
	// produce. A typed expectation replaces the model's results for the row.
	task automatic offer(input logic [7:0] b, input logic eoi, input bit typed = 1'b0,
		input logic tk = KIND_CHAR, input logic [7:0] tc = 8'h00, input logic tov = 1'b0);
		if (drain_req) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while (want_q.size() != 0)
				@(posedge clk);
			drain_req = 1'b0;
		end else if (!calm && !hold_req && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid     <= 1'b1;
		ch           <= b;
		end_of_input <= eoi;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		tokenize_byte(b, eoi);
		if (typed) begin
			step_res[0] = '{kind: tk, code: tc, last: 1'b1, ovf: tov};
			step_n      = 1;
		end
		for (int i = 0; i < step_n; i++)
			append_want(step_res[i]);
		if (step_n > max_burst)
			max_burst = step_n;
		if (eoi || blank_b(b))
			n_closes++;
		n_sent++;
	endtask

	task automatic send_fillers(input int cnt);
		repeat (cnt) offer(rand_filler(), 1'b0);
	endtask

	// One token: letter groups separated by filler runs, sometimes long
	// enough to fill the pending buffer. A broken token may end on fillers
	// or run into the next one without a closer.
	task automatic send_token(input bit broken);
		int segs;
		if ($urandom_range(0, 3) == 0)
			send_fillers($urandom_range(1, 3));
		segs = $urandom_range(1, 4);
		for (int s = 0; s < segs; s++) begin
			repeat ($urandom_range(1, 4)) offer(rand_letter(), 1'b0);
			if (s != segs - 1)
				send_fillers(($urandom_range(0, 7) == 0) ? $urandom_range(14, 20)
					: $urandom_range(1, 3));
		end
		if (broken || $urandom_range(0, 5) == 0)
			send_fillers($urandom_range(1, 4));
		if (!broken || $urandom_range(0, 1) == 0) begin
			if ($urandom_range(0, 3) == 0)
				offer(8'($urandom_range(0, 255)), 1'b1);
			else
				offer(rand_blank(), 1'b0);
		end
	endtask

	task automatic add_row(input logic [7:0] b, input logic eoi, input int reps = 1,
		input bit typed = 1'b0, input logic tk = KIND_CHAR, input logic [7:0] tc = 8'h00,
		input logic tov = 1'b0);
		dir_row_t r;
		r = '{b: b, eoi: eoi, reps: reps, typed: typed, tk: tk, tc: tc, tov: tov};
		dir_rows.insert(dir_rows.size(), r);
	endtask

	// Result checker.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			n_words++;
			if (overflow === 1'b1)
				n_ovf_res++;
			if (want_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, got kind %0d char %0d",
					$time, kind, out_char);
				n_err++;
			end else begin
				got_exp = want_q.pop_front();
				if (kind !== got_exp.kind) begin
					$display("%0t: kind mismatch, expected %0d, got %0d",
						$time, got_exp.kind, kind);
					n_err++;
				end
				if (out_char !== got_exp.code) begin
					$display("%0t: out_char mismatch, expected %0d, got %0d",
						$time, got_exp.code, out_char);
					n_err++;
				end
				if (last !== got_exp.last) begin
					$display("%0t: last mismatch, expected %0d, got %0d",
						$time, got_exp.last, last);
					n_err++;
				end
				if (overflow !== got_exp.ovf) begin
					$display("%0t: overflow mismatch, expected %0d, got %0d",
						$time, got_exp.ovf, overflow);
					n_err++;
				end
			end
		end
	end

	// Receiver: random stall bursts, one long hold on request, none at the end.
	initial begin
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYC) @(posedge clk);
				hold_req = 1'b0;
			end else if (calm) begin
				out_stall <= 1'b0;
				@(posedge clk);
			end else if ($urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat (($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
					: $urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	initial begin
		#6_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		int  n_dir;
		int  target;
		int  pick;
		bit  hold_done;
		bit  drain_done;

		tk_seen    = 1'b0;
		tk_open    = 1'b0;
		tk_prev    = 8'h00;
		pend_n     = 0;
		tk_dropped = 1'b0;
		hold_done  = 1'b0;
		drain_done = 1'b0;

		// Leading junk, letters at both ends of the alphabet, then each word
		// rule, a pending run that overflows, and both kinds of token close.
		add_row(8'h00, 1'b0);
		add_row("A", 1'b0, 1, 1'b1, KIND_CHAR, "a", 1'b0);
		add_row(APOSTROPHE_BYTE, 1'b0);
		add_row("z", 1'b0);
		add_row(HYPHEN_BYTE, 1'b0);
		add_row("Q", 1'b0);
		add_row(".", 1'b0);
		add_row("x", 1'b0);
		add_row("!", 1'b0);
		add_row("?", 1'b0);
		add_row(8'hFF, 1'b0, PEND - 1);
		add_row("d", 1'b0);
		add_row(" ", 1'b0, 1, 1'b1, KIND_MARK, 8'h00, 1'b1);
		add_row("b", 1'b0, 1, 1'b1, KIND_CHAR, "b", 1'b0);
		add_row("k", 1'b1, 1, 1'b1, KIND_MARK, 8'h00, 1'b0);
		add_row(8'd13, 1'b0);
		add_row(8'h80, 1'b1);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			repeat (dir_rows[i].reps)
				offer(dir_rows[i].b, dir_rows[i].eoi, dir_rows[i].typed, dir_rows[i].tk,
					dir_rows[i].tc, dir_rows[i].tov);

		n_dir  = n_sent;
		target = n_dir + N_RANDOM;
		while (n_sent < target) begin
			if (!hold_done && n_sent >= n_dir + 100) begin
				hold_req  = 1'b1;
				hold_done = 1'b1;
			end
			if (!drain_done && n_sent >= n_dir + 200) begin
				drain_req  = 1'b1;
				drain_done = 1'b1;
			end
			calm = (n_sent >= target - CALM_TAIL);
			pick = $urandom_range(0, 9);
			if (pick == 0)
				repeat ($urandom_range(1, 3))
					offer(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
			else
				send_token(pick == 1);
		end
		in_valid <= 1'b0;

		while (want_q.size() != 0)
			@(posedge clk);
		repeat (2 * PEND + 16) @(posedge clk);

		$display("Sent %0d bytes closing %0d tokens; checked %0d results, %0d with overflow,",
			n_sent, n_closes, n_words, n_ovf_res);
		$display("at most %0d results from one byte; %0d mismatches.", max_burst, n_err);
		if (n_err == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire

// File: files.f
rtl/wts_pkg.sv
rtl/wts_ctrl.sv
rtl/wts_dp.sv
rtl/word_tokenizer_stream.sv
test/tb_top.sv
